// ===== sv/spectral_flux_beat_detector_assert.svh =====
// Assertion macros used by the beat detector RTL.
`ifndef SPECTRAL_FLUX_BEAT_DETECTOR_ASSERT_SVH
`define SPECTRAL_FLUX_BEAT_DETECTOR_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define SFBD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Invariant checked at every rising clock edge outside reset.
`define SFBD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ===== sv/sfbd_pkg.sv =====
`default_nettype none
package sfbd_pkg;
	localparam int GAP_HISTORY = 6;
	localparam int POS_W = (GAP_HISTORY > 1) ? $clog2(GAP_HISTORY) : 1;
	localparam int FILL_W = $clog2(GAP_HISTORY + 1);

	localparam logic [16:0] IV_ALPHA = 17'd9830;
	localparam logic [16:0] IV_KEEP = 17'd55706;
	localparam logic [23:0] IV_RESET = 24'd128000;
	localparam logic [49:0] ROUND_HALF = 50'd32768;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [15:0] STRENGTH_MAX = 16'hFFFF;
	localparam logic [3:0] DIV_LAST = 4'd15;

	typedef enum logic [2:0] {
		REG_ALPHA = 3'd0,
		REG_THRESHOLD = 3'd1,
		REG_RISE = 3'd2,
		REG_MIN_GAP = 3'd3,
		REG_CLAMP_LO = 3'd4,
		REG_CLAMP_HI = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_AV1,
		S_AV2,
		S_AV3,
		S_LVL,
		S_RISE,
		S_DECIDE,
		S_DIV,
		S_LOAD,
		S_SORT,
		S_IV1,
		S_IV2,
		S_IV3,
		S_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== sv/spectral_flux_beat_detector.sv =====
// Spectral flux beat detector.
// Input stream: one request per frame, s_tdata = {now_ms, flux}, flux in the low 32 bits.
// Output stream: one result per input request on m_tdata; fields listed at the port.
// Configuration: cfg_wr_en with cfg_index and cfg_wdata writes one 16-bit register;
// write only while no request is in flight.
// Each request is worked through a single shared 32x17 multiplier under a sequencer:
// an idle state that accepts it, the AV1 to RISE states for the averages and level
// products and one decision state; then, on a beat whose excess is below the level, a
// one-bit-per-cycle divider for the strength (a saturated beat takes full strength),
// and after an earlier beat one load state, GAP_HISTORY odd-even sort passes and the
// IV1 to IV3 states for the interval average. The output state places the result in
// the output register; s_tready is high only when the sequencer is idle.
// When the receiver stalls, the finished result waits in the output register and the
// next request may be accepted, but its result is held until the register is free.
// Reset restores the register defaults, clears the averages, time base and ring
// counters; the interval average resets to 500 ms.
`default_nettype none
`include "spectral_flux_beat_detector_assert.svh"
module spectral_flux_beat_detector
	import sfbd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [63:0] s_tdata, // flux[31:0], now_ms[63:32]
	output logic m_tvalid,
	input wire logic m_tready,
	// beat[0], strength[16:1], above_level[17], rise_ok[18], gap_ok[19],
	// avg_interval[43:20], last_gap_ms[75:44], zero[79:76]
	output logic [79:0] m_tdata,
	input wire logic cfg_wr_en,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_wdata
);
	state_t state_q, state_d;

	logic [15:0] alpha_q, thr_q, rise_q, min_gap_q, clamp_lo_q, clamp_hi_q;

	logic [31:0] flux_q, now_q;
	logic [31:0] avg_q, prev_q, lbt_q, last_gap_q;
	logic [23:0] ia_q;
	logic seen_q, had_q;
	logic [POS_W-1:0] pos_q;
	logic [FILL_W-1:0] fill_q, sort_cnt_q;
	logic [15:0] ring_q [GAP_HISTORY];
	logic [16:0] sort_q [GAP_HISTORY];

	logic [31:0] mul_a;
	logic [16:0] mul_b;
	logic [48:0] prod_q, acc_q, lvl_q;
	logic [48:0] rem_q;
	logic [15:0] str_q;
	logic [3:0] div_cnt_q;
	logic above_q, rising_q, gap_ok_q, beat_q;
	logic out_valid_q;
	logic [79:0] out_q;

	logic [49:0] sum_w;
	logic [48:0] num_w, diff_w, rise_num_w, rem2_w;
	logic [31:0] since_w, clamp1_w, clamp2_w, avg0_w, flux_rise_w;
	logic above_w, rising_w, gap_ok_w, beat_w, sat_w, div_bit_w;
	logic [15:0] median_w;
	logic [POS_W-1:0] med_idx_w;

	assign sum_w = {1'b0, acc_q} + {1'b0, prod_q} + ROUND_HALF;
	assign avg0_w = (avg_q == 32'd0) ? flux_q : avg_q;
	assign num_w = {5'd0, flux_q, 12'd0};
	assign flux_rise_w = flux_q - prev_q;
	assign rise_num_w = {5'd0, flux_rise_w, 12'd0};
	assign since_w = now_q - lbt_q;
	assign gap_ok_w = since_w >= {16'd0, min_gap_q};
	assign above_w = num_w > lvl_q;
	assign rising_w = (flux_q > prev_q) && (rise_num_w > prod_q);
	assign beat_w = gap_ok_w && above_w && rising_w;
	assign diff_w = num_w - lvl_q;
	assign sat_w = diff_w >= lvl_q;
	assign clamp1_w = (since_w < {16'd0, clamp_lo_q}) ? {16'd0, clamp_lo_q} : since_w;
	assign clamp2_w = (clamp1_w > {16'd0, clamp_hi_q}) ? {16'd0, clamp_hi_q} : clamp1_w;
	assign rem2_w = {rem_q[47:0], 1'b0};
	assign div_bit_w = rem2_w >= lvl_q;
	assign med_idx_w = POS_W'(fill_q >> 1);
	assign median_w = sort_q[med_idx_w][15:0];

	always_comb begin
		mul_a = avg_q;
		mul_b = {1'b0, thr_q};
		unique case (state_q)
			S_AV1: begin
				mul_a = avg0_w;
				mul_b = ONE_Q16 - {1'b0, alpha_q};
			end
			S_AV2: begin
				mul_a = flux_q;
				mul_b = {1'b0, alpha_q};
			end
			S_RISE: mul_b = {1'b0, rise_q};
			S_IV1: begin
				mul_a = {8'd0, ia_q};
				mul_b = IV_KEEP;
			end
			S_IV2: begin
				mul_a = {8'd0, median_w, 8'd0};
				mul_b = IV_ALPHA;
			end
			default: mul_b = {1'b0, thr_q};
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_AV1;
				end
			end
			S_AV1: state_d = S_AV2;
			S_AV2: state_d = S_AV3;
			S_AV3: state_d = S_LVL;
			S_LVL: state_d = S_RISE;
			S_RISE: state_d = S_DECIDE;
			S_DECIDE: begin
				priority if (!beat_w) begin
					state_d = S_OUT;
				end else if (!sat_w) begin
					state_d = S_DIV;
				end else if (seen_q) begin
					state_d = S_LOAD;
				end else begin
					state_d = S_OUT;
				end
			end
			S_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = had_q ? S_LOAD : S_OUT;
				end
			end
			S_LOAD: state_d = S_SORT;
			S_SORT: begin
				if (sort_cnt_q == FILL_W'(GAP_HISTORY - 1)) begin
					state_d = S_IV1;
				end
			end
			S_IV1: state_d = S_IV2;
			S_IV2: state_d = S_IV3;
			S_IV3: state_d = S_OUT;
			S_OUT: begin
				if (!out_valid_q || m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 16'd13107;
			thr_q <= 16'd6963;
			rise_q <= 16'd492;
			min_gap_q <= 16'd430;
			clamp_lo_q <= 16'd430;
			clamp_hi_q <= 16'd800;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ALPHA: alpha_q <= cfg_wdata;
				REG_THRESHOLD: thr_q <= cfg_wdata;
				REG_RISE: rise_q <= cfg_wdata;
				REG_MIN_GAP: min_gap_q <= cfg_wdata;
				REG_CLAMP_LO: clamp_lo_q <= cfg_wdata;
				REG_CLAMP_HI: clamp_hi_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= 32'd0;
			prev_q <= 32'd0;
			lbt_q <= 32'd0;
			last_gap_q <= 32'd0;
			ia_q <= IV_RESET;
			seen_q <= 1'b0;
			had_q <= 1'b0;
			pos_q <= '0;
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_AV3: avg_q <= sum_w[47:16];
				S_DECIDE: begin
					prev_q <= flux_q;
					if (beat_w) begin
						lbt_q <= now_q;
						seen_q <= 1'b1;
						had_q <= seen_q;
						if (seen_q) begin
							last_gap_q <= since_w;
							pos_q <= (pos_q == POS_W'(GAP_HISTORY - 1)) ? '0 : pos_q + 1'b1;
							if (fill_q < FILL_W'(GAP_HISTORY)) begin
								fill_q <= fill_q + 1'b1;
							end
						end else begin
							last_gap_q <= 32'd0;
						end
					end
				end
				S_IV3: ia_q <= sum_w[39:16];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				flux_q <= s_tdata[31:0];
				now_q <= s_tdata[63:32];
			end
			S_AV2: acc_q <= prod_q;
			S_RISE: lvl_q <= prod_q;
			S_DECIDE: begin
				above_q <= above_w;
				rising_q <= rising_w;
				gap_ok_q <= gap_ok_w;
				beat_q <= beat_w;
				rem_q <= diff_w;
				div_cnt_q <= '0;
				str_q <= (beat_w && sat_w) ? STRENGTH_MAX : 16'd0;
				if (beat_w && seen_q) begin
					ring_q[pos_q] <= clamp2_w[15:0];
				end
			end
			S_DIV: begin
				div_cnt_q <= div_cnt_q + 1'b1;
				str_q <= {str_q[14:0], div_bit_w};
				rem_q <= div_bit_w ? rem2_w - lvl_q : rem2_w;
			end
			S_LOAD: begin
				sort_cnt_q <= '0;
				for (int i = 0; i < GAP_HISTORY; i++) begin
					sort_q[i] <= {(FILL_W'(i) >= fill_q), ring_q[i]};
				end
			end
			S_SORT: begin
				sort_cnt_q <= sort_cnt_q + 1'b1;
				for (int i = 0; i < GAP_HISTORY - 1; i++) begin
					if ((i % 2) == int'(sort_cnt_q[0]) && sort_q[i] > sort_q[i + 1]) begin
						sort_q[i] <= sort_q[i + 1];
						sort_q[i + 1] <= sort_q[i];
					end
				end
			end
			S_IV2: acc_q <= prod_q;
			S_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_q <= {4'd0, last_gap_q, ia_q, gap_ok_q, rising_q, above_q,
						str_q, beat_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

	`SFBD_ASSERT_ALWAYS(a_fill_range, fill_q <= FILL_W'(GAP_HISTORY), "ring fill overflow")
	`SFBD_ASSERT_ALWAYS(a_pos_range, pos_q < POS_W'(GAP_HISTORY), "ring position out of range")
	`SFBD_ASSERT_IMP(a_beat_flags, m_tvalid && m_tdata[0],
		m_tdata[17] && m_tdata[18] && m_tdata[19], "beat without all conditions")
	`SFBD_ASSERT_IMP(a_no_beat_zero, m_tvalid && !m_tdata[0], m_tdata[16:1] == 16'd0, "strength without beat")
	`SFBD_ASSERT_IMP(a_hold_result, m_tvalid && !m_tready, ##1 m_tvalid, "result dropped under stall")
endmodule
`default_nettype wire
